### sv/mbr_pkg.sv
// ============================================================================
// mbr_pkg - shared types and constants for the multi-buffer ring manager
// Item field widths, command and stage codes, and the per-item result record.
// ============================================================================
package mbr_pkg;

    localparam int DATA_W      = 32;  // push_word / read_word
    localparam int SLOT_W      = 8;   // read_slot
    localparam int FILL_OUT_W  = 9;   // read_fill
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 40;  // push_word, read_slot
    localparam int OUT_TDATA_W = 48;  // result fields, zero padded

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH     = 2'd0,
        MODE_READ     = 2'd1,
        MODE_RELEASE  = 2'd2,
        MODE_COMPLETE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_ADDING   = 2'd0,
        PH_FINISHED = 2'd1,
        PH_ALL_READ = 2'd2
    } phase_t;

    // result of one item; read_ready, read_fill, all_read and stage are taken after the state update
    typedef struct packed {
        logic                  accepted;
        logic                  read_ready;
        logic                  hit;        // read_word comes from the word RAM
        logic [FILL_OUT_W-1:0] read_fill;
        logic                  all_read;
        phase_t                stage;
    } mbr_result_t;

endpackage

### sv/mbr_word_mem.sv
// ============================================================================
// mbr_word_mem - word storage of the buffer ring
// Single-port synchronous RAM, one access per cycle, registered read data.
// ============================================================================
module mbr_word_mem #(
    parameter int WORD_WIDTH = 32,
    parameter int DEPTH      = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WORD_WIDTH-1:0]                   wdata,
    output logic [WORD_WIDTH-1:0]                   rdata
);

    logic [WORD_WIDTH-1:0] mem_ram [DEPTH];
    logic [WORD_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_ram[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_ram[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/mbr_ctrl.sv
// ============================================================================
// mbr_ctrl - ring pointers, write fill count and stage
// Decodes one command per item, updates the ring state and issues the RAM
// access. Fill of any buffer other than the write buffer follows from the
// pointers: buffers from read up to write hold CAPACITY words, the rest none.
// ============================================================================
module mbr_ctrl import mbr_pkg::*; #(
    parameter int NUM_BUFFERS = 4,
    parameter int CAPACITY    = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  mode_t               mode,
    input  logic [DATA_W-1:0]   push_word,
    input  logic [SLOT_W-1:0]   read_slot,
    output logic                mem_we,
    output logic                mem_re,
    output logic [((NUM_BUFFERS * CAPACITY > 1) ?
                   $clog2(NUM_BUFFERS * CAPACITY) : 1)-1:0] mem_addr,
    output logic [WORD_WIDTH-1:0] mem_wdata,
    output mbr_result_t         res
);

    localparam int DEPTH  = NUM_BUFFERS * CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > SLOT_W) ? FILL_W : SLOT_W;
    localparam int FX_W   = (FILL_W > FILL_OUT_W) ? FILL_W : FILL_OUT_W;
    localparam int XW     = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BUFFERS - 1);
    localparam logic [FILL_W-1:0] CAP_F    = FILL_W'(CAPACITY);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [FILL_W-1:0] wfill_reg, wfill_next;
    phase_t            phase_reg, phase_next;

    logic              avail_pre, avail_post, slot_hit;
    logic              w_full, push_ok;
    logic              acc_c, hit_c;
    logic [IDX_W-1:0]  w_nxt, eff_w, e_nxt;
    logic [FILL_W-1:0] eff_f, new_f, rfill_pre, rfill_post;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [FX_W-1:0]   rfill_ext;
    logic [XW-1:0]     push_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg  <= '0;
            ridx_reg  <= '0;
            wfill_reg <= '0;
            phase_reg <= PH_ADDING;
        end
        else if (item_valid)
        begin
            widx_reg  <= widx_next;
            ridx_reg  <= ridx_next;
            wfill_reg <= wfill_next;
            phase_reg <= phase_next;
        end
    end

    assign avail_pre = (phase_reg != PH_ALL_READ) &&
                       !(phase_reg == PH_ADDING && ridx_reg == widx_reg);
    assign rfill_pre = (ridx_reg == widx_reg) ? wfill_reg : CAP_F;
    assign slot_hit  = CMP_W'(read_slot) < CMP_W'(rfill_pre);

    // a full write buffer hands over to the next one before storing
    assign w_full  = (wfill_reg == CAP_F);
    assign w_nxt   = ring_next(widx_reg);
    assign eff_w   = w_full ? w_nxt : widx_reg;
    assign eff_f   = w_full ? '0 : wfill_reg;
    assign new_f   = eff_f + 1'b1;
    assign e_nxt   = ring_next(eff_w);
    assign push_ok = (phase_reg == PH_ADDING) && !(w_full && w_nxt == ridx_reg);

    assign wr_addr  = ADDR_W'(eff_w) * ADDR_W'(CAPACITY) + ADDR_W'(eff_f);
    assign rd_addr  = ADDR_W'(ridx_reg) * ADDR_W'(CAPACITY) + ADDR_W'(read_slot);
    assign push_ext = XW'(push_word);
    assign mem_wdata = push_ext[WORD_WIDTH-1:0];

    always_comb
    begin
        widx_next  = widx_reg;
        ridx_next  = ridx_reg;
        wfill_next = wfill_reg;
        phase_next = phase_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = rd_addr;
        acc_c      = 1'b0;
        hit_c      = 1'b0;
        unique case (mode)
            MODE_PUSH:
            begin
                if (push_ok)
                begin
                    mem_we   = item_valid;
                    mem_addr = wr_addr;
                    acc_c    = 1'b1;
                    if (new_f == CAP_F && e_nxt != ridx_reg)
                    begin
                        widx_next  = e_nxt;
                        wfill_next = '0;
                    end
                    else
                    begin
                        widx_next  = eff_w;
                        wfill_next = new_f;
                    end
                end
            end
            MODE_READ:
            begin
                if (avail_pre && slot_hit)
                begin
                    hit_c  = 1'b1;
                    mem_re = item_valid;
                end
            end
            MODE_RELEASE:
            begin
                if (avail_pre)
                begin
                    if (ridx_reg == widx_reg)
                    begin
                        wfill_next = '0;
                        phase_next = PH_ALL_READ;
                    end
                    else
                    begin
                        ridx_next = ring_next(ridx_reg);
                    end
                end
            end
            MODE_COMPLETE:
            begin
                phase_next = PH_FINISHED;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // status after the update
    assign avail_post = (phase_next != PH_ALL_READ) &&
                        !(phase_next == PH_ADDING && ridx_next == widx_next);
    assign rfill_post = (ridx_next == widx_next) ? wfill_next : CAP_F;
    assign rfill_ext  = FX_W'(rfill_post);

    assign res.accepted   = acc_c;
    assign res.hit        = hit_c;
    assign res.read_ready = avail_post;
    assign res.read_fill  = avail_post ? rfill_ext[FILL_OUT_W-1:0] : '0;
    assign res.all_read   = (phase_next == PH_ALL_READ);
    assign res.stage      = phase_next;

endmodule

### sv/multi_buffer_ring_manager.sv
// ============================================================================
// multi_buffer_ring_manager - producer/consumer ring of word buffers
// Top level: item stream in, command decode, word RAM, result stream out.
// ============================================================================
// The block keeps NUM_BUFFERS buffers of CAPACITY words in one single-port
// RAM and walks them as a ring: a producer pushes words into the write
// buffer, a consumer reads words of the read buffer by slot, releases it and
// finally the producer marks adding complete. Each input item carries a
// command in s_axis_tuser and yields exactly one result item. The command
// decode and pointer update happen at acceptance, together with the single
// RAM access (write for push, read for read), so the one RAM port sets the
// rate of one item per clock while the output is not stalled. A result
// passes the pending stage, which waits for the RAM read data, and then the
// output register. The pending stage and the output register together let
// input and output stall independently without losing throughput. The word
// RAM needs no clearing after reset: a slot is only read below the fill count
// of its buffer, so it has always been written first.
// ============================================================================
module multi_buffer_ring_manager import mbr_pkg::*; #(
    parameter int NUM_BUFFERS = 4,
    parameter int CAPACITY    = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] push_word, [39:32] read_slot
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] accepted, [1] read_ready, [33:2] read_word, [42:34] read_fill,
    // [43] all_read, [45:44] stage_now, [47:46] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int DEPTH  = NUM_BUFFERS * CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;

    // handshake
    logic              accept, out_free, pend_move;

    // decode / RAM access
    mbr_result_t       ctrl_res;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;
    logic [XW-1:0]     rdata_ext;

    // pending stage: waits for the RAM read data
    logic              pend_valid_reg;
    mbr_result_t       pend_res_reg;

    // output register
    logic              out_valid_reg;
    mbr_result_t       out_res_reg;
    logic [DATA_W-1:0] out_word_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pend_move     = pend_valid_reg && out_free;
    assign s_axis_tready = !pend_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mbr_ctrl #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .CAPACITY    (CAPACITY),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (accept),
        .mode       (mode_t'(s_axis_tuser)),
        .push_word  (s_axis_tdata[DATA_W-1:0]),
        .read_slot  (s_axis_tdata[DATA_W+SLOT_W-1:DATA_W]),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .res        (ctrl_res)
    );

    mbr_word_mem #(
        .WORD_WIDTH (WORD_WIDTH),
        .DEPTH      (DEPTH)
    ) u_word_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign rdata_ext = XW'(mem_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_res_reg <= ctrl_res;
        end
        if (pend_move)
        begin
            out_res_reg  <= pend_res_reg;
            // RAM data is only valid for a read that hit a stored slot
            out_word_reg <= pend_res_reg.hit ? rdata_ext[DATA_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_res_reg.stage,
                            out_res_reg.all_read,
                            out_res_reg.read_fill,
                            out_word_reg,
                            out_res_reg.read_ready,
                            out_res_reg.accepted};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // no buffer available: nothing to report for fill or data
    a_unavail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.read_ready) |->
            (out_res_reg.read_fill == '0 && out_word_reg == '0))
        else $error("unavailable buffer reports fill or data");

    // a stored push leaves the ring in the adding stage
    a_push_adding: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.accepted) |-> (out_res_reg.stage == PH_ADDING))
        else $error("push stored outside adding stage");

    // every accepted item lands in the pending stage
    a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_valid_reg)
        else $error("accepted item lost before pending stage");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking bench for the multi-buffer ring manager
// Streams push/read/release/complete commands into the block with random
// gaps and output stalls, predicts every result item from a behavioral model
// of the buffer ring, and checks each result item field by field in order.
// ============================================================================
module tb_top;
    import mbr_pkg::*;

    localparam int NBUF = 4;
    localparam int CAP  = 256;

    // one command for the block, plus a flag that holds it back until all
    // earlier result items have come out
    typedef struct {
        mode_t       mode;
        logic [31:0] word;
        logic [7:0]  slot;
        bit          drain;
    } ring_cmd_t;

    // one expected result item
    typedef struct {
        logic        accepted;
        logic        ready;
        logic [31:0] word;
        logic [8:0]  fill;
        logic        all_read;
        phase_t      stage;
    } ring_view_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    multi_buffer_ring_manager #(
        .NUM_BUFFERS (NBUF),
        .CAPACITY    (CAP),
        .WORD_WIDTH  (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Ring model: word store, fill counts, write/read buffer index, stage
    // ------------------------------------------------------------------------
    logic [31:0] ring_words [0:NBUF*CAP-1];
    logic [8:0]  ring_fill  [0:NBUF-1];
    int unsigned wr_buf;
    int unsigned rd_buf;
    phase_t      ring_stage;

    ring_cmd_t   pending_cmds[$];
    ring_view_t  expected_results[$];
    int unsigned mismatches = 0;
    int unsigned queued = 0;

    function automatic int unsigned next_buf(input int unsigned idx);
        return (idx + 1 >= NBUF) ? 0 : idx + 1;
    endfunction

    // consumer side sees a buffer unless all is read, or the producer is
    // still adding into the very buffer the consumer points at
    function automatic logic buf_open();
        if (ring_stage == PH_ALL_READ)
            return 1'b0;
        if (ring_stage == PH_ADDING && rd_buf == wr_buf)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic ring_predict(input mode_t m, input logic [31:0] w,
                                input logic [7:0] slot, output ring_view_t v);
        logic        ok;
        logic        open;
        int unsigned nxt;
        v.accepted = 1'b0;
        v.word     = '0;
        case (m)
            MODE_PUSH:
            begin
                if (ring_stage == PH_ADDING)
                begin
                    ok = 1'b1;
                    // full write buffer: try to step onto the next one first
                    if (ring_fill[wr_buf] >= CAP)
                    begin
                        nxt = next_buf(wr_buf);
                        if (nxt == rd_buf)
                            ok = 1'b0;
                        else
                        begin
                            wr_buf = nxt;
                            if (ring_fill[wr_buf] >= CAP)
                                ok = 1'b0;
                        end
                    end
                    if (ok)
                    begin
                        ring_words[wr_buf*CAP + ring_fill[wr_buf]] = w;
                        ring_fill[wr_buf] = ring_fill[wr_buf] + 1;
                        if (ring_fill[wr_buf] >= CAP && next_buf(wr_buf) != rd_buf)
                            wr_buf = next_buf(wr_buf);
                    end
                    v.accepted = ok;
                end
            end
            MODE_READ:
            begin
                if (buf_open() && slot < ring_fill[rd_buf])
                    v.word = ring_words[rd_buf*CAP + slot];
            end
            MODE_RELEASE:
            begin
                if (buf_open())
                begin
                    ring_fill[rd_buf] = '0;
                    if (rd_buf == wr_buf)
                        ring_stage = PH_ALL_READ;
                    else
                        rd_buf = next_buf(rd_buf);
                end
            end
            default:
                ring_stage = PH_FINISHED;
        endcase
        open       = buf_open();
        v.ready    = open;
        v.fill     = open ? ring_fill[rd_buf] : 9'd0;
        v.all_read = (ring_stage == PH_ALL_READ);
        v.stage    = ring_stage;
    endtask

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long; calm stretches
    // switch idling off altogether
    // ------------------------------------------------------------------------
    bit calm_in  = 1'b0;
    bit calm_out = 1'b0;

    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input mode_t m, input logic [31:0] w,
                             input logic [7:0] slot, input bit drain = 1'b0);
        ring_cmd_t c;
        c.mode  = m;
        c.word  = w;
        c.slot  = slot;
        c.drain = drain;
        pending_cmds.insert(pending_cmds.size(), c);
        queued++;
    endtask

    // slots biased toward both ends of a buffer, where fill limits bite
    function automatic logic [7:0] pick_slot();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return 8'($urandom_range(15));
        if (r < 75)
            return 8'($urandom_range(255, 240));
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_pushes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_cmd(MODE_PUSH, $urandom(), 8'($urandom_range(255)));
    endtask

    task automatic queue_reads(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_cmd(MODE_READ, $urandom(), pick_slot());
    endtask

    task automatic queue_noise(input int unsigned top_mode);
        queue_cmd(mode_t'($urandom_range(top_mode)), $urandom(), 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // Monitor: acceptance on both sides at the rising edge
    // ------------------------------------------------------------------------
    bit         in_took = 1'b0;
    ring_view_t got_view;
    ring_view_t want_view;

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        in_took = rst_n && s_axis_tvalid && s_axis_tready;
        if ($urandom_range(199) == 0)
            calm_in = ~calm_in;
        if ($urandom_range(199) == 0)
            calm_out = ~calm_out;
        if (in_took)
        begin
            ring_predict(mode_t'(s_axis_tuser), s_axis_tdata[31:0],
                         s_axis_tdata[39:32], got_view);
            expected_results.insert(expected_results.size(), got_view);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no expectation waiting: 0x%0h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_view = expected_results.pop_front();
                check_field("accepted",   want_view.accepted, m_axis_tdata[0]);
                check_field("read_ready", want_view.ready,    m_axis_tdata[1]);
                check_field("read_word",  want_view.word,     m_axis_tdata[33:2]);
                check_field("read_fill",  want_view.fill,     m_axis_tdata[42:34]);
                check_field("all_read",   want_view.all_read, m_axis_tdata[43]);
                check_field("stage_now",  want_view.stage,    m_axis_tdata[45:44]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: next command at the falling edge once the last one was taken
    // ------------------------------------------------------------------------
    int unsigned in_gap = 0;
    int unsigned out_hold = 0;
    ring_cmd_t   cur_cmd;

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_took))
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0))
            begin
                cur_cmd = pending_cmds.pop_front();
                s_axis_tdata  <= {cur_cmd.slot, cur_cmd.word};
                s_axis_tuser  <= cur_cmd.mode;
                s_axis_tvalid <= 1'b1;
                in_gap = idle_len(calm_in);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (out_hold == 0 && $urandom_range(99) < 30)
            out_hold = idle_len(calm_out);
        if (out_hold != 0)
        begin
            out_hold--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        bit          flooded;
        for (int i = 0; i < NBUF*CAP; i++)
            ring_words[i] = '0;
        for (int i = 0; i < NBUF; i++)
            ring_fill[i] = '0;
        wr_buf     = 0;
        rd_buf     = 0;
        ring_stage = PH_ADDING;
        flooded    = 1'b0;

        // Directed: consumer with nothing to see, word and slot extremes.
        // Complete is held back to the closing part since adding never
        // restarts once it ends.
        queue_cmd(MODE_READ,    32'h0000_0000, 8'd0);
        queue_cmd(MODE_RELEASE, 32'hFFFF_FFFF, 8'd255);   // nothing to release
        queue_cmd(MODE_PUSH,    32'h0000_0000, 8'd0);
        queue_cmd(MODE_PUSH,    32'hFFFF_FFFF, 8'd255);
        queue_cmd(MODE_PUSH,    32'h8000_0001, 8'hAA);
        queue_cmd(MODE_PUSH,    32'h5555_AAAA, 8'h55);
        queue_cmd(MODE_READ,    32'hFFFF_FFFF, 8'd0);     // write buffer only
        queue_cmd(MODE_READ,    32'h0000_0000, 8'd255);
        queue_cmd(MODE_RELEASE, 32'h0000_0000, 8'd0);
        queue_cmd(MODE_PUSH,    32'h7FFF_FFFF, 8'd1, 1'b1);

        // Random, adding stage: push bursts, read bursts, releases, noise.
        // One long run of pushes fills a whole buffer and moves the write
        // side on to the next one, so full buffers are read at both ends.
        while (queued < 310)
        begin
            r = $urandom_range(99);
            if (!flooded && queued > 40)
            begin
                flooded = 1'b1;
                queue_pushes(CAP + 8);
                queue_cmd(MODE_READ, $urandom(), 8'd255);
                queue_cmd(MODE_READ, $urandom(), 8'd254);
                queue_cmd(MODE_READ, $urandom(), 8'd0);
                queue_reads(6);
                queue_cmd(MODE_RELEASE, $urandom(), 8'($urandom_range(255)));
                queue_pushes(20);
                queue_cmd(MODE_RELEASE, $urandom(), 8'($urandom_range(255)));
            end
            else if (r < 45)
                queue_pushes(($urandom_range(9) == 0) ? $urandom_range(60, 30)
                                                      : $urandom_range(24, 1));
            else if (r < 70)
                queue_reads($urandom_range(8, 1));
            else if (r < 82)
                queue_cmd(MODE_RELEASE, $urandom(), 8'($urandom_range(255)));
            else if (r < 84)
                queue_cmd(MODE_PUSH, $urandom(), 8'($urandom_range(255)), 1'b1);
            else
                queue_noise(MODE_RELEASE);
        end

        // Closing: end adding after a full drain, read everything out,
        // poke the completely-read stage, then complete again from there.
        queue_cmd(MODE_COMPLETE, $urandom(), 8'($urandom_range(255)), 1'b1);
        queue_cmd(MODE_PUSH, $urandom(), 8'd0);               // not adding
        for (int i = 0; i < NBUF + 1; i++)
        begin
            queue_cmd(MODE_READ, $urandom(), 8'd0);
            queue_cmd(MODE_READ, $urandom(), 8'd255);
            queue_reads(2);
            queue_cmd(MODE_RELEASE, $urandom(), 8'($urandom_range(255)));
        end
        queue_cmd(MODE_RELEASE, $urandom(), 8'd0);            // all read already
        queue_cmd(MODE_READ,    $urandom(), 8'd0);
        queue_cmd(MODE_COMPLETE, $urandom(), 8'd0);           // from all read
        queue_cmd(MODE_READ,    $urandom(), 8'd0);
        queue_cmd(MODE_RELEASE, $urandom(), 8'd0);
        for (int i = 0; i < 60; i++)
            queue_noise(MODE_COMPLETE);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #15_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### multi_buffer_ring_manager.f
sv/mbr_pkg.sv
sv/mbr_word_mem.sv
sv/mbr_ctrl.sv
sv/multi_buffer_ring_manager.sv
test/tb_top.sv
